// File: rtl/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types, opcode constants and the per-operation attribute table for
// the RV64I instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

    // major opcodes, bits 6:0 of the instruction word
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6f;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OPIMM    = 7'h13;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_OPIMM32  = 7'h1b;
    localparam logic [6:0] OPC_OP32     = 7'h3b;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;

    // the only two system words that are accepted
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    // funct3 values
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // funct7 / funct6 qualifiers
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_ALT  = 6'h10;

    // memory access kind
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOADS = 2'd1;
    localparam logic [1:0] MEM_LOADU = 2'd2;
    localparam logic [1:0] MEM_STORE = 2'd3;

    // control-flow class
    localparam logic [1:0] FLOW_SEQ  = 2'd0;
    localparam logic [1:0] FLOW_JUMP = 2'd1;
    localparam logic [1:0] FLOW_HALT = 2'd2;

    typedef enum logic [5:0] {
        OP_ILLEGAL = 6'd0,
        OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
        OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU,
        OP_SB, OP_SH, OP_SW, OP_SD,
        OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
        OP_SLLI, OP_SRLI, OP_SRAI,
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
        OP_OR, OP_AND,
        OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
        OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW,
        OP_FENCE, OP_ECALL, OP_EBREAK
    } t_op;

    typedef struct packed {
        logic       rd1;
        logic       rd2;
        logic       wr;
        logic [1:0] kind;
        logic [3:0] bytes;
        logic [1:0] flow;
    } t_attr;

    typedef struct packed {
        logic               illegal;
        t_op                operation;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic               reads_src1;
        logic               reads_src2;
        logic               writes_dest;
        logic [1:0]         mem_kind;
        logic [3:0]         access_bytes;
        logic [1:0]         flow_class;
    } t_dec_result;

    // register use, memory access and flow class of each operation
    function automatic t_attr op_attr(input t_op op);
        t_attr a;
        a = '0;
        case (op) inside
            OP_LUI, OP_AUIPC: a.wr = 1'b1;
            OP_JAL: begin
                a.wr   = 1'b1;
                a.flow = FLOW_JUMP;
            end
            OP_JALR: begin
                a.rd1  = 1'b1;
                a.wr   = 1'b1;
                a.flow = FLOW_JUMP;
            end
            [OP_BEQ:OP_BGEU]: begin
                a.rd1  = 1'b1;
                a.rd2  = 1'b1;
                a.flow = FLOW_JUMP;
            end
            [OP_LB:OP_LW]: begin
                a.rd1  = 1'b1;
                a.wr   = 1'b1;
                a.kind = MEM_LOADS;
            end
            [OP_LD:OP_LWU]: begin
                a.rd1  = 1'b1;
                a.wr   = 1'b1;
                a.kind = MEM_LOADU;
            end
            [OP_SB:OP_SD]: begin
                a.rd1  = 1'b1;
                a.rd2  = 1'b1;
                a.kind = MEM_STORE;
            end
            [OP_ADDI:OP_SRAI], [OP_ADDIW:OP_SRAIW]: begin
                a.rd1 = 1'b1;
                a.wr  = 1'b1;
            end
            [OP_ADD:OP_AND], [OP_ADDW:OP_SRAW]: begin
                a.rd1 = 1'b1;
                a.rd2 = 1'b1;
                a.wr  = 1'b1;
            end
            OP_ECALL, OP_EBREAK: a.flow = FLOW_HALT;
            default: a = '0;
        endcase
        // access size
        case (op)
            OP_LB, OP_LBU, OP_SB: a.bytes = 4'd1;
            OP_LH, OP_LHU, OP_SH: a.bytes = 4'd2;
            OP_LW, OP_LWU, OP_SW: a.bytes = 4'd4;
            OP_LD, OP_SD:         a.bytes = 4'd8;
            default:              a.bytes = 4'd0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/rvdec_decode.sv
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational decode of one instruction word into the operation number,
// register indices, immediate and attribute flags.
// ----------------------------------------------------------------------------
module rvdec_decode (
    input  logic [31:0]               i_word,
    output rvdec_pkg::t_dec_result    o_result
);

    logic [6:0]        w_opc;
    logic [2:0]        w_f3;
    logic [6:0]        w_f7;
    logic [5:0]        w_f6;
    rvdec_pkg::t_op    w_op;
    rvdec_pkg::t_attr  w_attr;
    logic [31:0]       w_imm;
    logic [31:0]       w_imm_i;
    logic [31:0]       w_imm_s;
    logic [31:0]       w_imm_b;
    logic [31:0]       w_imm_j;

    assign w_opc = i_word[6:0];
    assign w_f3  = i_word[14:12];
    assign w_f7  = i_word[31:25];
    assign w_f6  = i_word[31:26];

    // immediate forms
    assign w_imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign w_imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign w_imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                      i_word[11:8], 1'b0};
    assign w_imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                      i_word[30:21], 1'b0};

    // operation select
    always_comb begin
        w_op = rvdec_pkg::OP_ILLEGAL;
        case (w_opc)
            rvdec_pkg::OPC_LUI:   w_op = rvdec_pkg::OP_LUI;
            rvdec_pkg::OPC_AUIPC: w_op = rvdec_pkg::OP_AUIPC;
            rvdec_pkg::OPC_JAL:   w_op = rvdec_pkg::OP_JAL;
            rvdec_pkg::OPC_JALR: begin
                if (w_f3 == rvdec_pkg::F3_0) w_op = rvdec_pkg::OP_JALR;
            end
            rvdec_pkg::OPC_BRANCH: begin
                case (w_f3)
                    rvdec_pkg::F3_0: w_op = rvdec_pkg::OP_BEQ;
                    rvdec_pkg::F3_1: w_op = rvdec_pkg::OP_BNE;
                    rvdec_pkg::F3_4: w_op = rvdec_pkg::OP_BLT;
                    rvdec_pkg::F3_5: w_op = rvdec_pkg::OP_BGE;
                    rvdec_pkg::F3_6: w_op = rvdec_pkg::OP_BLTU;
                    rvdec_pkg::F3_7: w_op = rvdec_pkg::OP_BGEU;
                    default:         w_op = rvdec_pkg::OP_ILLEGAL;
                endcase
            end
            rvdec_pkg::OPC_LOAD: begin
                // loads are numbered in funct3 order, funct3 of 7 is unused
                if (w_f3 != rvdec_pkg::F3_7)
                    w_op = rvdec_pkg::t_op'(6'(rvdec_pkg::OP_LB) + {3'b000, w_f3});
            end
            rvdec_pkg::OPC_STORE: begin
                if (!w_f3[2])
                    w_op = rvdec_pkg::t_op'(6'(rvdec_pkg::OP_SB) + {3'b000, w_f3});
            end
            rvdec_pkg::OPC_OPIMM: begin
                case (w_f3)
                    rvdec_pkg::F3_0: w_op = rvdec_pkg::OP_ADDI;
                    rvdec_pkg::F3_1: begin
                        if (w_f6 == rvdec_pkg::F6_BASE) w_op = rvdec_pkg::OP_SLLI;
                    end
                    rvdec_pkg::F3_2: w_op = rvdec_pkg::OP_SLTI;
                    rvdec_pkg::F3_3: w_op = rvdec_pkg::OP_SLTIU;
                    rvdec_pkg::F3_4: w_op = rvdec_pkg::OP_XORI;
                    rvdec_pkg::F3_5: begin
                        if (w_f6 == rvdec_pkg::F6_BASE)
                            w_op = rvdec_pkg::OP_SRLI;
                        else if (w_f6 == rvdec_pkg::F6_ALT)
                            w_op = rvdec_pkg::OP_SRAI;
                    end
                    rvdec_pkg::F3_6: w_op = rvdec_pkg::OP_ORI;
                    rvdec_pkg::F3_7: w_op = rvdec_pkg::OP_ANDI;
                    default:         w_op = rvdec_pkg::OP_ILLEGAL;
                endcase
            end
            rvdec_pkg::OPC_OP: begin
                if (w_f7 == rvdec_pkg::F7_BASE) begin
                    case (w_f3)
                        rvdec_pkg::F3_0: w_op = rvdec_pkg::OP_ADD;
                        rvdec_pkg::F3_1: w_op = rvdec_pkg::OP_SLL;
                        rvdec_pkg::F3_2: w_op = rvdec_pkg::OP_SLT;
                        rvdec_pkg::F3_3: w_op = rvdec_pkg::OP_SLTU;
                        rvdec_pkg::F3_4: w_op = rvdec_pkg::OP_XOR;
                        rvdec_pkg::F3_5: w_op = rvdec_pkg::OP_SRL;
                        rvdec_pkg::F3_6: w_op = rvdec_pkg::OP_OR;
                        rvdec_pkg::F3_7: w_op = rvdec_pkg::OP_AND;
                        default:         w_op = rvdec_pkg::OP_ILLEGAL;
                    endcase
                end else if (w_f7 == rvdec_pkg::F7_ALT) begin
                    if (w_f3 == rvdec_pkg::F3_0)
                        w_op = rvdec_pkg::OP_SUB;
                    else if (w_f3 == rvdec_pkg::F3_5)
                        w_op = rvdec_pkg::OP_SRA;
                end
            end
            rvdec_pkg::OPC_OPIMM32: begin
                if (w_f3 == rvdec_pkg::F3_0)
                    w_op = rvdec_pkg::OP_ADDIW;
                else if (w_f3 == rvdec_pkg::F3_1 && w_f7 == rvdec_pkg::F7_BASE)
                    w_op = rvdec_pkg::OP_SLLIW;
                else if (w_f3 == rvdec_pkg::F3_5 && w_f7 == rvdec_pkg::F7_BASE)
                    w_op = rvdec_pkg::OP_SRLIW;
                else if (w_f3 == rvdec_pkg::F3_5 && w_f7 == rvdec_pkg::F7_ALT)
                    w_op = rvdec_pkg::OP_SRAIW;
            end
            rvdec_pkg::OPC_OP32: begin
                if (w_f3 == rvdec_pkg::F3_0 && w_f7 == rvdec_pkg::F7_BASE)
                    w_op = rvdec_pkg::OP_ADDW;
                else if (w_f3 == rvdec_pkg::F3_0 && w_f7 == rvdec_pkg::F7_ALT)
                    w_op = rvdec_pkg::OP_SUBW;
                else if (w_f3 == rvdec_pkg::F3_1 && w_f7 == rvdec_pkg::F7_BASE)
                    w_op = rvdec_pkg::OP_SLLW;
                else if (w_f3 == rvdec_pkg::F3_5 && w_f7 == rvdec_pkg::F7_BASE)
                    w_op = rvdec_pkg::OP_SRLW;
                else if (w_f3 == rvdec_pkg::F3_5 && w_f7 == rvdec_pkg::F7_ALT)
                    w_op = rvdec_pkg::OP_SRAW;
            end
            // every misc-mem word decodes as fence
            rvdec_pkg::OPC_MISC_MEM: w_op = rvdec_pkg::OP_FENCE;
            rvdec_pkg::OPC_SYSTEM: begin
                if (i_word == rvdec_pkg::WORD_ECALL)
                    w_op = rvdec_pkg::OP_ECALL;
                else if (i_word == rvdec_pkg::WORD_EBREAK)
                    w_op = rvdec_pkg::OP_EBREAK;
            end
            default: w_op = rvdec_pkg::OP_ILLEGAL;
        endcase
    end

    // immediate select, zero for illegal words and formats without one
    always_comb begin
        case (w_op) inside
            rvdec_pkg::OP_LUI, rvdec_pkg::OP_AUIPC:
                w_imm = {i_word[31:12], 12'h000};
            rvdec_pkg::OP_JAL:
                w_imm = w_imm_j;
            [rvdec_pkg::OP_BEQ:rvdec_pkg::OP_BGEU]:
                w_imm = w_imm_b;
            rvdec_pkg::OP_JALR, [rvdec_pkg::OP_LB:rvdec_pkg::OP_LWU],
            [rvdec_pkg::OP_ADDI:rvdec_pkg::OP_ANDI], rvdec_pkg::OP_ADDIW:
                w_imm = w_imm_i;
            [rvdec_pkg::OP_SB:rvdec_pkg::OP_SD]:
                w_imm = w_imm_s;
            [rvdec_pkg::OP_SLLI:rvdec_pkg::OP_SRAI]:
                w_imm = {26'd0, i_word[25:20]};
            [rvdec_pkg::OP_SLLIW:rvdec_pkg::OP_SRAIW]:
                w_imm = {27'd0, i_word[24:20]};
            default:
                w_imm = 32'd0;
        endcase
    end

    assign w_attr = rvdec_pkg::op_attr(w_op);

    // result assembly
    always_comb begin
        o_result.illegal      = (w_op == rvdec_pkg::OP_ILLEGAL);
        o_result.operation    = w_op;
        o_result.dest_reg     = w_attr.wr  ? i_word[11:7]  : 5'd0;
        o_result.src1_reg     = w_attr.rd1 ? i_word[19:15] : 5'd0;
        o_result.src2_reg     = w_attr.rd2 ? i_word[24:20] : 5'd0;
        o_result.immediate    = w_imm;
        o_result.reads_src1   = w_attr.rd1;
        o_result.reads_src2   = w_attr.rd2;
        o_result.writes_dest  = w_attr.wr;
        o_result.mem_kind     = w_attr.kind;
        o_result.access_bytes = w_attr.bytes;
        o_result.flow_class   = w_attr.flow;
    end

endmodule

// File: rtl/rv64i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv64i_instruction_decoder
// RV64I instruction decoder with a registered request word and a registered
// result, valid/stall handshake on both sides.
// ----------------------------------------------------------------------------
// Each request carries one 32-bit instruction word and yields exactly one
// result, in order. A request is captured in the input register, decoded by
// one pass of combinational logic and written to the result register, and a
// new request is taken every cycle while the result side keeps up; throughput
// is one word per clock, set by the single decode pass between the two
// registers. If the result side stalls, the result register holds and o_stall
// rises once the input register is also full. Illegal words return illegal
// set and every other field zero. There is no configuration and no internal
// state beyond the two pipeline registers.
module rv64i_instruction_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_instr_word,
    // result side
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_illegal,
    output logic [5:0]         o_operation,
    output logic [4:0]         o_dest_reg,
    output logic [4:0]         o_src1_reg,
    output logic [4:0]         o_src2_reg,
    output logic signed [31:0] o_immediate,
    output logic               o_reads_src1,
    output logic               o_reads_src2,
    output logic               o_writes_dest,
    output logic [1:0]         o_mem_kind,
    output logic [3:0]         o_access_bytes,
    output logic [1:0]         o_flow_class
);

    logic                   r_in_valid;
    logic [31:0]            r_in_word;
    logic                   r_out_valid;
    rvdec_pkg::t_dec_result r_out;
    rvdec_pkg::t_dec_result w_dec;
    logic                   w_out_hold;
    logic                   w_in_adv;
    logic                   w_in_take;

    // pipeline flow control
    assign w_out_hold = r_out_valid && i_stall;
    assign w_in_adv   = r_in_valid && !w_out_hold;
    assign o_stall    = r_in_valid && w_out_hold;
    assign w_in_take  = i_valid && !o_stall;

    // decode pass
    rvdec_decode u_decode (
        .i_word   (r_in_word),
        .o_result (w_dec)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall)
                r_in_valid <= i_valid;
            if (!w_out_hold)
                r_out_valid <= r_in_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take)
            r_in_word <= i_instr_word;
        if (w_in_adv)
            r_out <= w_dec;
    end

    // result ports
    assign o_valid        = r_out_valid;
    assign o_illegal      = r_out.illegal;
    assign o_operation    = 6'(r_out.operation);
    assign o_dest_reg     = r_out.dest_reg;
    assign o_src1_reg     = r_out.src1_reg;
    assign o_src2_reg     = r_out.src2_reg;
    assign o_immediate    = r_out.immediate;
    assign o_reads_src1   = r_out.reads_src1;
    assign o_reads_src2   = r_out.reads_src2;
    assign o_writes_dest  = r_out.writes_dest;
    assign o_mem_kind     = r_out.mem_kind;
    assign o_access_bytes = r_out.access_bytes;
    assign o_flow_class   = r_out.flow_class;

    // a decoded request reaches the result register in the following cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_adv |=> o_valid)
        else $error("decoded request did not reach the result register");

    // the block only pushes back while it holds a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("stall raised with a free pipeline register");

    // illegal words carry no other information
    a_illegal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_illegal |-> o_operation == 6'd0 && o_immediate == 32'sd0 &&
            o_dest_reg == 5'd0 && o_src1_reg == 5'd0 && o_src2_reg == 5'd0 &&
            o_mem_kind == rvdec_pkg::MEM_NONE && o_flow_class == rvdec_pkg::FLOW_SEQ)
        else $error("illegal result with nonzero fields");

    // memory kind and access size agree
    a_mem_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mem_kind == rvdec_pkg::MEM_NONE) == (o_access_bytes == 4'd0))
        else $error("memory kind and access size disagree");

endmodule

// File: verif/tb_rv64i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// tb_rv64i_instruction_decoder
// Self-checking bench for the RV64I instruction decoder. A queue of
// instruction words (hand-picked corner words, then biased random words) is
// streamed into the decoder under random request gaps and result stalls. Each
// accepted word is decoded by a behavioral decoder in the bench, and every
// result is checked field by field against the oldest pending decode.
// ----------------------------------------------------------------------------
module tb_rv64i_instruction_decoder;

    localparam int RANDOM_WORDS = 1625;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PERCENT = 26;
    // window of cycles in which neither side idles
    localparam int QUIET_START  = 1200;
    localparam int QUIET_END    = 1800;

    typedef struct {
        logic [31:0]            word;
        rvdec_pkg::t_dec_result fields;
    } t_decode_expect;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [31:0]        i_instr_word = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_illegal;
    logic [5:0]         o_operation;
    logic [4:0]         o_dest_reg;
    logic [4:0]         o_src1_reg;
    logic [4:0]         o_src2_reg;
    logic signed [31:0] o_immediate;
    logic               o_reads_src1;
    logic               o_reads_src2;
    logic               o_writes_dest;
    logic [1:0]         o_mem_kind;
    logic [3:0]         o_access_bytes;
    logic [1:0]         o_flow_class;

    logic [31:0]        pending_words [$];
    t_decode_expect     decoded_q [$];
    t_decode_expect     oldest;
    logic               req_taken = 1'b0;
    int                 cycle_count = 0;
    int                 mismatches = 0;

    rv64i_instruction_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_instr_word   (i_instr_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_illegal      (o_illegal),
        .o_operation    (o_operation),
        .o_dest_reg     (o_dest_reg),
        .o_src1_reg     (o_src1_reg),
        .o_src2_reg     (o_src2_reg),
        .o_immediate    (o_immediate),
        .o_reads_src1   (o_reads_src1),
        .o_reads_src2   (o_reads_src2),
        .o_writes_dest  (o_writes_dest),
        .o_mem_kind     (o_mem_kind),
        .o_access_bytes (o_access_bytes),
        .o_flow_class   (o_flow_class)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // behavioral decode of one instruction word
    function automatic rvdec_pkg::t_dec_result decode_word(input logic [31:0] w);
        rvdec_pkg::t_dec_result r;
        rvdec_pkg::t_op         op;
        logic [31:0]            imm;
        logic [6:0]             opc;
        logic [2:0]             f3;
        logic [6:0]             f7;
        logic [5:0]             f6;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        f6  = w[31:26];
        op  = rvdec_pkg::OP_ILLEGAL;
        imm = '0;
        case (opc)
            rvdec_pkg::OPC_LUI: begin
                op  = rvdec_pkg::OP_LUI;
                imm = {w[31:12], 12'b0};
            end
            rvdec_pkg::OPC_AUIPC: begin
                op  = rvdec_pkg::OP_AUIPC;
                imm = {w[31:12], 12'b0};
            end
            rvdec_pkg::OPC_JAL: begin
                op  = rvdec_pkg::OP_JAL;
                imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            end
            rvdec_pkg::OPC_JALR: begin
                if (f3 == rvdec_pkg::F3_0) op = rvdec_pkg::OP_JALR;
                imm = {{20{w[31]}}, w[31:20]};
            end
            rvdec_pkg::OPC_BRANCH: begin
                case (f3)
                    rvdec_pkg::F3_0: op = rvdec_pkg::OP_BEQ;
                    rvdec_pkg::F3_1: op = rvdec_pkg::OP_BNE;
                    rvdec_pkg::F3_4: op = rvdec_pkg::OP_BLT;
                    rvdec_pkg::F3_5: op = rvdec_pkg::OP_BGE;
                    rvdec_pkg::F3_6: op = rvdec_pkg::OP_BLTU;
                    rvdec_pkg::F3_7: op = rvdec_pkg::OP_BGEU;
                    default: op = rvdec_pkg::OP_ILLEGAL;
                endcase
                imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            end
            rvdec_pkg::OPC_LOAD: begin
                case (f3)
                    rvdec_pkg::F3_0: op = rvdec_pkg::OP_LB;
                    rvdec_pkg::F3_1: op = rvdec_pkg::OP_LH;
                    rvdec_pkg::F3_2: op = rvdec_pkg::OP_LW;
                    rvdec_pkg::F3_3: op = rvdec_pkg::OP_LD;
                    rvdec_pkg::F3_4: op = rvdec_pkg::OP_LBU;
                    rvdec_pkg::F3_5: op = rvdec_pkg::OP_LHU;
                    rvdec_pkg::F3_6: op = rvdec_pkg::OP_LWU;
                    default: op = rvdec_pkg::OP_ILLEGAL;
                endcase
                imm = {{20{w[31]}}, w[31:20]};
            end
            rvdec_pkg::OPC_STORE: begin
                case (f3)
                    rvdec_pkg::F3_0: op = rvdec_pkg::OP_SB;
                    rvdec_pkg::F3_1: op = rvdec_pkg::OP_SH;
                    rvdec_pkg::F3_2: op = rvdec_pkg::OP_SW;
                    rvdec_pkg::F3_3: op = rvdec_pkg::OP_SD;
                    default: op = rvdec_pkg::OP_ILLEGAL;
                endcase
                imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            rvdec_pkg::OPC_OPIMM: begin
                imm = {{20{w[31]}}, w[31:20]};
                case (f3)
                    rvdec_pkg::F3_0: op = rvdec_pkg::OP_ADDI;
                    rvdec_pkg::F3_2: op = rvdec_pkg::OP_SLTI;
                    rvdec_pkg::F3_3: op = rvdec_pkg::OP_SLTIU;
                    rvdec_pkg::F3_4: op = rvdec_pkg::OP_XORI;
                    rvdec_pkg::F3_6: op = rvdec_pkg::OP_ORI;
                    rvdec_pkg::F3_7: op = rvdec_pkg::OP_ANDI;
                    rvdec_pkg::F3_1: begin
                        if (f6 == rvdec_pkg::F6_BASE) op = rvdec_pkg::OP_SLLI;
                        imm = {26'b0, w[25:20]};
                    end
                    default: begin
                        if (f6 == rvdec_pkg::F6_BASE) op = rvdec_pkg::OP_SRLI;
                        else if (f6 == rvdec_pkg::F6_ALT) op = rvdec_pkg::OP_SRAI;
                        imm = {26'b0, w[25:20]};
                    end
                endcase
            end
            rvdec_pkg::OPC_OP: begin
                if (f7 == rvdec_pkg::F7_BASE) begin
                    case (f3)
                        rvdec_pkg::F3_0: op = rvdec_pkg::OP_ADD;
                        rvdec_pkg::F3_1: op = rvdec_pkg::OP_SLL;
                        rvdec_pkg::F3_2: op = rvdec_pkg::OP_SLT;
                        rvdec_pkg::F3_3: op = rvdec_pkg::OP_SLTU;
                        rvdec_pkg::F3_4: op = rvdec_pkg::OP_XOR;
                        rvdec_pkg::F3_5: op = rvdec_pkg::OP_SRL;
                        rvdec_pkg::F3_6: op = rvdec_pkg::OP_OR;
                        default: op = rvdec_pkg::OP_AND;
                    endcase
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_0) begin
                    op = rvdec_pkg::OP_SUB;
                end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_5) begin
                    op = rvdec_pkg::OP_SRA;
                end
            end
            rvdec_pkg::OPC_OPIMM32: begin
                imm = {27'b0, w[24:20]};
                if (f3 == rvdec_pkg::F3_0) begin
                    op  = rvdec_pkg::OP_ADDIW;
                    imm = {{20{w[31]}}, w[31:20]};
                end else if (f3 == rvdec_pkg::F3_1 && f7 == rvdec_pkg::F7_BASE) begin
                    op = rvdec_pkg::OP_SLLIW;
                end else if (f3 == rvdec_pkg::F3_5 && f7 == rvdec_pkg::F7_BASE) begin
                    op = rvdec_pkg::OP_SRLIW;
                end else if (f3 == rvdec_pkg::F3_5 && f7 == rvdec_pkg::F7_ALT) begin
                    op = rvdec_pkg::OP_SRAIW;
                end
            end
            rvdec_pkg::OPC_OP32: begin
                if (f3 == rvdec_pkg::F3_0 && f7 == rvdec_pkg::F7_BASE)
                    op = rvdec_pkg::OP_ADDW;
                else if (f3 == rvdec_pkg::F3_0 && f7 == rvdec_pkg::F7_ALT)
                    op = rvdec_pkg::OP_SUBW;
                else if (f3 == rvdec_pkg::F3_1 && f7 == rvdec_pkg::F7_BASE)
                    op = rvdec_pkg::OP_SLLW;
                else if (f3 == rvdec_pkg::F3_5 && f7 == rvdec_pkg::F7_BASE)
                    op = rvdec_pkg::OP_SRLW;
                else if (f3 == rvdec_pkg::F3_5 && f7 == rvdec_pkg::F7_ALT)
                    op = rvdec_pkg::OP_SRAW;
            end
            // fence ignores every bit above the opcode
            rvdec_pkg::OPC_MISC_MEM: op = rvdec_pkg::OP_FENCE;
            rvdec_pkg::OPC_SYSTEM: begin
                if (w == rvdec_pkg::WORD_ECALL) op = rvdec_pkg::OP_ECALL;
                else if (w == rvdec_pkg::WORD_EBREAK) op = rvdec_pkg::OP_EBREAK;
            end
            default: op = rvdec_pkg::OP_ILLEGAL;
        endcase

        // register use, memory access and flow class
        r = '0;
        case (op)
            rvdec_pkg::OP_ILLEGAL, rvdec_pkg::OP_FENCE: ;
            rvdec_pkg::OP_LUI, rvdec_pkg::OP_AUIPC: r.writes_dest = 1'b1;
            rvdec_pkg::OP_JAL: begin
                r.writes_dest = 1'b1;
                r.flow_class  = rvdec_pkg::FLOW_JUMP;
            end
            rvdec_pkg::OP_JALR: begin
                r.reads_src1  = 1'b1;
                r.writes_dest = 1'b1;
                r.flow_class  = rvdec_pkg::FLOW_JUMP;
            end
            rvdec_pkg::OP_BEQ, rvdec_pkg::OP_BNE, rvdec_pkg::OP_BLT, rvdec_pkg::OP_BGE,
            rvdec_pkg::OP_BLTU, rvdec_pkg::OP_BGEU: begin
                r.reads_src1 = 1'b1;
                r.reads_src2 = 1'b1;
                r.flow_class = rvdec_pkg::FLOW_JUMP;
            end
            rvdec_pkg::OP_LB, rvdec_pkg::OP_LH, rvdec_pkg::OP_LW: begin
                r.reads_src1  = 1'b1;
                r.writes_dest = 1'b1;
                r.mem_kind    = rvdec_pkg::MEM_LOADS;
            end
            // ld is reported as a zero-extending load
            rvdec_pkg::OP_LD, rvdec_pkg::OP_LBU, rvdec_pkg::OP_LHU,
            rvdec_pkg::OP_LWU: begin
                r.reads_src1  = 1'b1;
                r.writes_dest = 1'b1;
                r.mem_kind    = rvdec_pkg::MEM_LOADU;
            end
            rvdec_pkg::OP_SB, rvdec_pkg::OP_SH, rvdec_pkg::OP_SW, rvdec_pkg::OP_SD: begin
                r.reads_src1 = 1'b1;
                r.reads_src2 = 1'b1;
                r.mem_kind   = rvdec_pkg::MEM_STORE;
            end
            rvdec_pkg::OP_ADD, rvdec_pkg::OP_SUB, rvdec_pkg::OP_SLL, rvdec_pkg::OP_SLT,
            rvdec_pkg::OP_SLTU, rvdec_pkg::OP_XOR, rvdec_pkg::OP_SRL, rvdec_pkg::OP_SRA,
            rvdec_pkg::OP_OR, rvdec_pkg::OP_AND, rvdec_pkg::OP_ADDW, rvdec_pkg::OP_SUBW,
            rvdec_pkg::OP_SLLW, rvdec_pkg::OP_SRLW, rvdec_pkg::OP_SRAW: begin
                r.reads_src1  = 1'b1;
                r.reads_src2  = 1'b1;
                r.writes_dest = 1'b1;
            end
            rvdec_pkg::OP_ECALL, rvdec_pkg::OP_EBREAK:
                r.flow_class = rvdec_pkg::FLOW_HALT;
            // remaining operations are register-immediate
            default: begin
                r.reads_src1  = 1'b1;
                r.writes_dest = 1'b1;
            end
        endcase
        case (op)
            rvdec_pkg::OP_LB, rvdec_pkg::OP_LBU, rvdec_pkg::OP_SB: r.access_bytes = 4'd1;
            rvdec_pkg::OP_LH, rvdec_pkg::OP_LHU, rvdec_pkg::OP_SH: r.access_bytes = 4'd2;
            rvdec_pkg::OP_LW, rvdec_pkg::OP_LWU, rvdec_pkg::OP_SW: r.access_bytes = 4'd4;
            rvdec_pkg::OP_LD, rvdec_pkg::OP_SD:                    r.access_bytes = 4'd8;
            default:                                               r.access_bytes = 4'd0;
        endcase

        r.illegal   = (op == rvdec_pkg::OP_ILLEGAL);
        r.operation = op;
        r.dest_reg  = r.writes_dest ? w[11:7] : 5'd0;
        r.src1_reg  = r.reads_src1 ? w[19:15] : 5'd0;
        r.src2_reg  = r.reads_src2 ? w[24:20] : 5'd0;
        r.immediate = r.illegal ? 32'sd0 : imm;
        return r;
    endfunction

    // random word, mostly steered onto supported opcodes and qualifiers
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(99) < 12) return w;
        case ($urandom_range(12))
            0:  w[6:0] = rvdec_pkg::OPC_LUI;
            1:  w[6:0] = rvdec_pkg::OPC_AUIPC;
            2:  w[6:0] = rvdec_pkg::OPC_JAL;
            3:  w[6:0] = rvdec_pkg::OPC_JALR;
            4:  w[6:0] = rvdec_pkg::OPC_BRANCH;
            5:  w[6:0] = rvdec_pkg::OPC_LOAD;
            6:  w[6:0] = rvdec_pkg::OPC_STORE;
            7:  w[6:0] = rvdec_pkg::OPC_OPIMM;
            8:  w[6:0] = rvdec_pkg::OPC_OP;
            9:  w[6:0] = rvdec_pkg::OPC_OPIMM32;
            10: w[6:0] = rvdec_pkg::OPC_OP32;
            11: w[6:0] = rvdec_pkg::OPC_MISC_MEM;
            default: w[6:0] = rvdec_pkg::OPC_SYSTEM;
        endcase
        // funct7 mostly base or alternate, bit 25 usually clear
        if ($urandom_range(99) < 75) begin
            w[31:26] = $urandom_range(1) ? rvdec_pkg::F7_ALT[6:1] : rvdec_pkg::F7_BASE[6:1];
            if ($urandom_range(99) < 70) w[25] = 1'b0;
        end
        if (w[6:0] == rvdec_pkg::OPC_SYSTEM && $urandom_range(99) < 60)
            w = $urandom_range(1) ? rvdec_pkg::WORD_EBREAK : rvdec_pkg::WORD_ECALL;
        return w;
    endfunction

    function automatic logic idle_now();
        if (cycle_count >= QUIET_START && cycle_count < QUIET_END) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    task automatic compare_field(input string field_name, input logic [31:0] want,
                                 input logic [31:0] got, input logic [31:0] word);
        if (got !== want) begin
            $display("%0t: word %h %s mismatch: expected %h, actual %h",
                     $time, word, field_name, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || req_taken) begin
                if (pending_words.size() != 0 && !idle_now()) begin
                    i_valid      <= 1'b1;
                    i_instr_word <= pending_words.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= idle_now();
        end
    end

    // request capture and result check
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            decoded_q.push_back('{i_instr_word, decode_word(i_instr_word)});
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: result with no request outstanding: expected none, actual op %0d",
                         $time, o_operation);
                mismatches++;
            end else begin
                oldest = decoded_q.pop_front();
                compare_field("illegal", 32'(oldest.fields.illegal), 32'(o_illegal),
                              oldest.word);
                compare_field("operation", 32'(oldest.fields.operation), 32'(o_operation),
                              oldest.word);
                compare_field("dest_reg", 32'(oldest.fields.dest_reg), 32'(o_dest_reg),
                              oldest.word);
                compare_field("src1_reg", 32'(oldest.fields.src1_reg), 32'(o_src1_reg),
                              oldest.word);
                compare_field("src2_reg", 32'(oldest.fields.src2_reg), 32'(o_src2_reg),
                              oldest.word);
                compare_field("immediate", oldest.fields.immediate, o_immediate, oldest.word);
                compare_field("reads_src1", 32'(oldest.fields.reads_src1), 32'(o_reads_src1),
                              oldest.word);
                compare_field("reads_src2", 32'(oldest.fields.reads_src2), 32'(o_reads_src2),
                              oldest.word);
                compare_field("writes_dest", 32'(oldest.fields.writes_dest),
                              32'(o_writes_dest), oldest.word);
                compare_field("mem_kind", 32'(oldest.fields.mem_kind), 32'(o_mem_kind),
                              oldest.word);
                compare_field("access_bytes", 32'(oldest.fields.access_bytes),
                              32'(o_access_bytes), oldest.word);
                compare_field("flow_class", 32'(oldest.fields.flow_class), 32'(o_flow_class),
                              oldest.word);
            end
        end
    end

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        // corner words: extremes, system, fence, shift fields, other formats
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'hFFFF_FFFF);
        pending_words.push_back(rvdec_pkg::WORD_ECALL);
        pending_words.push_back(rvdec_pkg::WORD_EBREAK);
        pending_words.push_back(rvdec_pkg::WORD_EBREAK | 32'h0000_0080);
        pending_words.push_back({12'h001, 5'd0, rvdec_pkg::F3_1, 5'd0,
                                 rvdec_pkg::OPC_SYSTEM});
        pending_words.push_back({25'h1FF_FFFF, rvdec_pkg::OPC_MISC_MEM});
        pending_words.push_back({rvdec_pkg::F6_BASE, 6'd63, 5'd31, rvdec_pkg::F3_1, 5'd31,
                                 rvdec_pkg::OPC_OPIMM});
        pending_words.push_back({rvdec_pkg::F6_ALT, 6'd63, 5'd2, rvdec_pkg::F3_5, 5'd1,
                                 rvdec_pkg::OPC_OPIMM});
        pending_words.push_back({6'h01, 6'd5, 5'd2, rvdec_pkg::F3_5, 5'd1,
                                 rvdec_pkg::OPC_OPIMM});
        pending_words.push_back({rvdec_pkg::F7_ALT, 5'd31, 5'd3, rvdec_pkg::F3_5, 5'd4,
                                 rvdec_pkg::OPC_OPIMM32});
        pending_words.push_back({7'h01, 5'd1, 5'd3, rvdec_pkg::F3_1, 5'd4,
                                 rvdec_pkg::OPC_OPIMM32});
        pending_words.push_back({12'hFFF, 5'd31, rvdec_pkg::F3_3, 5'd31,
                                 rvdec_pkg::OPC_LOAD});
        pending_words.push_back({12'h7FF, 5'd0, rvdec_pkg::F3_7, 5'd1,
                                 rvdec_pkg::OPC_LOAD});
        pending_words.push_back({20'hFFFFF, 5'd31, rvdec_pkg::OPC_LUI});
        pending_words.push_back({20'h80000, 5'd1, rvdec_pkg::OPC_AUIPC});
        pending_words.push_back({20'h80000, 5'd1, rvdec_pkg::OPC_JAL});
        pending_words.push_back({20'h7FFFF, 5'd31, rvdec_pkg::OPC_JAL});
        pending_words.push_back({12'h800, 5'd5, rvdec_pkg::F3_1, 5'd6,
                                 rvdec_pkg::OPC_JALR});
        pending_words.push_back({7'h7F, 5'd31, 5'd31, rvdec_pkg::F3_2, 5'd31,
                                 rvdec_pkg::OPC_BRANCH});
        pending_words.push_back({7'h7F, 5'd31, 5'd31, rvdec_pkg::F3_7, 5'd31,
                                 rvdec_pkg::OPC_BRANCH});
        pending_words.push_back({7'h3F, 5'd0, 5'd0, rvdec_pkg::F3_3, 5'd31,
                                 rvdec_pkg::OPC_STORE});
        pending_words.push_back({7'h40, 5'd1, 5'd1, rvdec_pkg::F3_4, 5'd1,
                                 rvdec_pkg::OPC_STORE});
        pending_words.push_back({rvdec_pkg::F7_ALT, 5'd2, 5'd1, rvdec_pkg::F3_0, 5'd1,
                                 rvdec_pkg::OPC_OP});
        pending_words.push_back({7'h01, 5'd2, 5'd1, rvdec_pkg::F3_0, 5'd1,
                                 rvdec_pkg::OPC_OP});
        pending_words.push_back({rvdec_pkg::F7_ALT, 5'd31, 5'd31, rvdec_pkg::F3_5, 5'd31,
                                 rvdec_pkg::OPC_OP32});
        for (int n = 0; n < RANDOM_WORDS; n++)
            pending_words.push_back(random_word());

        // reset held, then released on a falling clock edge
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go in and every result to come back
        while (pending_words.size() != 0 || i_valid || decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
